// File: src/hs_pkg.sv
// Shared constants and types for the hashed stack.
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  // Number of slots in the stack store.
  localparam int DEPTH = 16;

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 5;
  localparam int HASH_W  = 64;

  // Value left in a slot that holds no entry.
  localparam logic [DATA_W-1:0] EMPTY_MARK = 32'd666;

  // Commands.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Hash unit operations.
  localparam int HOP_W = 3;
  localparam logic [HOP_W-1:0] HOP_NONE = 3'd0;
  localparam logic [HOP_W-1:0] HOP_CLR  = 3'd1;
  localparam logic [HOP_W-1:0] HOP_MIX  = 3'd2;
  localparam logic [HOP_W-1:0] HOP_FIN1 = 3'd3;
  localparam logic [HOP_W-1:0] HOP_FIN2 = 3'd4;
  localparam logic [HOP_W-1:0] HOP_FIN3 = 3'd5;

  // Control from the sequencer to the hash unit.
  typedef struct packed {
    logic [HOP_W-1:0] op;
    logic [7:0]       data_byte;
  } hash_ctl_t;

endpackage

`default_nettype wire

// File: src/hs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/hs_hash_unit.sv
// Shared one-at-a-time hash step unit with its accumulator register.
`timescale 1ns / 1ps
`default_nettype none

module hs_hash_unit (
  input  wire logic                    clk,
  input  wire hs_pkg::hash_ctl_t       ctl,
  output logic [hs_pkg::HASH_W-1:0]    hash
);

  logic [hs_pkg::HASH_W-1:0] h_r;
  logic [hs_pkg::HASH_W-1:0] h_nxt;
  logic [hs_pkg::HASH_W-1:0] t_add;
  logic [hs_pkg::HASH_W-1:0] t_mul;

  always_comb begin
    t_add = h_r + {{(hs_pkg::HASH_W - 8){1'b0}}, ctl.data_byte};
    t_mul = t_add + (t_add << 10);
    case (ctl.op)
      hs_pkg::HOP_CLR:  h_nxt = '0;
      hs_pkg::HOP_MIX:  h_nxt = t_mul ^ (t_mul >> 6);
      hs_pkg::HOP_FIN1: h_nxt = h_r + (h_r << 3);
      hs_pkg::HOP_FIN2: h_nxt = h_r ^ (h_r >> 11);
      hs_pkg::HOP_FIN3: h_nxt = h_r + (h_r << 15);
      default:          h_nxt = h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  assign hash = h_r;

endmodule

`default_nettype wire

// File: src/hashed_stack.sv
// Top level of the hashed stack: sequencer, stack pointer and output register.
`timescale 1ns / 1ps
`default_nettype none

// A stack of DEPTH signed 32-bit words. Each input word is a push or a pop;
// each one yields exactly one result word with a status, the popped value
// (zero unless a pop succeeded), the entry count after the operation and a
// 64-bit one-at-a-time hash over the low byte of every slot, used or not.
// After every operation the sequencer sweeps the slot RAM from index 0 with
// one read per cycle, folding each byte into the shared hash unit, then runs
// three finalization steps. A push, or any rejected operation, holds the
// block through the sweep, finalization and hand-over before the next
// word is accepted; a successful pop first passes a capture state for its
// RAM read. The sweep through the single RAM read port takes most of this
// time. A finished result waits in the output register, and a new word is
// accepted meanwhile; the block only holds back the next result while the
// previous one is still stalled. Slots out of reset read as the marker 666
// through per-slot valid flags, so no clearing pass is needed.
module hashed_stack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic signed [31:0]            in_push_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic signed [31:0]                 out_popped_value,
  output logic [4:0]                         out_entry_count,
  output logic [63:0]                        out_content_hash
);

  localparam int ADDR_W = hs_pkg::ADDR_W;
  localparam int CNT_W  = hs_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POP_CAP = 3'd1;
  localparam logic [2:0] S_HASH    = 3'd2;
  localparam logic [2:0] S_HLAST   = 3'd3;
  localparam logic [2:0] S_FIN1    = 3'd4;
  localparam logic [2:0] S_FIN2    = 3'd5;
  localparam logic [2:0] S_FIN3    = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(hs_pkg::DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(hs_pkg::DEPTH);

  // Control state.
  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [hs_pkg::DEPTH-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic                     mix_pend_r, mix_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [hs_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [hs_pkg::DATA_W-1:0] popped_r, popped_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [1:0]                out_status_r;
  logic [31:0]               out_popped_r;
  logic [4:0]                out_count_r;
  logic [63:0]               out_hash_r;
  logic                      load_out;

  // RAM port signals.
  logic                      ram_wr_en;
  logic [ADDR_W-1:0]         ram_wr_addr;
  logic                      ram_rd_en;
  logic [ADDR_W-1:0]         ram_rd_addr;
  logic [hs_pkg::DATA_W-1:0] ram_rd_data;

  hs_pkg::hash_ctl_t         hash_ctl;
  logic [hs_pkg::HASH_W-1:0] hash_val;

  logic                      in_acc;
  logic [ADDR_W-1:0]         top_addr;
  logic [ADDR_W-1:0]         below_addr;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign top_addr   = count_r[ADDR_W-1:0];
  assign below_addr = ADDR_W'(count_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    mix_pend_nxt  = mix_pend_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    rd_vld_nxt    = rd_vld_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = top_addr;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r;
    hash_ctl.op   = hs_pkg::HOP_NONE;
    // A slot that was never written, or was freed by a pop, reads as the marker.
    hash_ctl.data_byte = rd_vld_r ? ram_rd_data[7:0] : hs_pkg::EMPTY_MARK[7:0];
    load_out      = 1'b0;

    case (state_r)
      S_IDLE: begin
        hash_ctl.op  = hs_pkg::HOP_CLR;
        idx_nxt      = '0;
        mix_pend_nxt = 1'b0;
        if (in_acc) begin
          popped_nxt = '0;
          status_nxt = hs_pkg::ST_OK;
          state_nxt  = S_HASH;
          if (in_cmd == hs_pkg::CMD_PUSH) begin
            if (count_r >= FULL_CNT) begin
              status_nxt = hs_pkg::ST_FULL;
            end else begin
              ram_wr_en          = 1'b1;
              valid_nxt[top_addr] = 1'b1;
              count_nxt          = count_r + 1'b1;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = hs_pkg::ST_EMPTY;
            end else begin
              // Fetch the top entry; it is captured in the next cycle.
              ram_rd_en   = 1'b1;
              ram_rd_addr = below_addr;
              state_nxt   = S_POP_CAP;
            end
          end
        end
      end
      S_POP_CAP: begin
        hash_ctl.op           = hs_pkg::HOP_CLR;
        popped_nxt            = ram_rd_data;
        valid_nxt[below_addr] = 1'b0;
        count_nxt             = count_r - 1'b1;
        state_nxt             = S_HASH;
      end
      S_HASH: begin
        // Read slot idx while the byte of the previous slot is folded in.
        ram_rd_en    = 1'b1;
        rd_vld_nxt   = valid_r[idx_r];
        mix_pend_nxt = 1'b1;
        if (mix_pend_r) begin
          hash_ctl.op = hs_pkg::HOP_MIX;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_HLAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_HLAST: begin
        hash_ctl.op  = hs_pkg::HOP_MIX;
        mix_pend_nxt = 1'b0;
        state_nxt    = S_FIN1;
      end
      S_FIN1: begin
        hash_ctl.op = hs_pkg::HOP_FIN1;
        state_nxt   = S_FIN2;
      end
      S_FIN2: begin
        hash_ctl.op = hs_pkg::HOP_FIN2;
        state_nxt   = S_FIN3;
      end
      S_FIN3: begin
        hash_ctl.op = hs_pkg::HOP_FIN3;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      idx_r       <= '0;
      mix_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      mix_pend_r  <= mix_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    rd_vld_r <= rd_vld_nxt;
    if (load_out) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_count_r  <= 5'(count_r);
      out_hash_r   <= hash_val;
    end
  end

  hs_ram #(
    .WIDTH (hs_pkg::DATA_W),
    .DEPTH (hs_pkg::DEPTH),
    .ADDR_W(ADDR_W)
  ) u_slots (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(in_push_value),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  hs_hash_unit u_hash (
    .clk (clk),
    .ctl (hash_ctl),
    .hash(hash_val)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_entry_count  = out_count_r;
  assign out_content_hash = out_hash_r;

endmodule

`default_nettype wire

// File: src/hs_checker.sv
// Port-level checks for the hashed stack, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_cmd,
  input wire logic signed [31:0] in_push_value,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_popped_value,
  input wire logic [4:0]         out_entry_count,
  input wire logic [63:0]        out_content_hash
);

  // An input word held off by the block stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_push_value))
    else $error("stalled input word changed");

  // A stalled result word stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_popped_value) && $stable(out_entry_count) &&
      $stable(out_content_hash))
    else $error("stalled result word changed");

  // Only a successful pop returns a value.
  a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hs_pkg::ST_OK |-> out_popped_value == 0)
    else $error("rejected operation returned a value");

  // A rejected push means the stack is full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hs_pkg::ST_FULL |->
      out_entry_count == 5'(hs_pkg::DEPTH))
    else $error("full status with stack not full");

  // A rejected pop means the stack is empty.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hs_pkg::ST_EMPTY |-> out_entry_count == 5'd0)
    else $error("empty status with entries held");

endmodule

bind hashed_stack hs_checker u_hs_checker (.*);

`default_nettype wire
